// File: hdl/sid_pkg.sv
// Shared types for the signed integer divider.
// No dependencies; imported by the divide core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

   // Commands from the top level to the divide core
   typedef struct packed {
      logic start;   // load a new operand pair
      logic take;    // the finished quotient moves to the output register
   } sid_ctl_type;

   // Status from the divide core to the top level
   typedef struct packed {
      logic ready;   // the core is free for a new operand pair
      logic done;    // the quotient and flag are final
   } sid_sts_type;

endpackage

`default_nettype wire

// File: hdl/sid_req_if.sv
// Request channel: valid/ready handshake carrying a dividend and a divisor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sid_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend;
   logic signed [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

// File: hdl/sid_rsp_if.sv
// Response channel: valid/ready handshake carrying the quotient and the flag.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sid_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic                         special_case;

   modport source (output valid, output quotient, output special_case, input ready);
   modport sink   (input valid, input quotient, input special_case, output ready);
endinterface

`default_nettype wire

// File: hdl/sid_core.sv
// Divide core: magnitudes, restoring division one quotient bit per cycle, sign fix-up.
// Depends on sid_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sid_core
   import sid_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sid_ctl_type           ctl,
   output      sid_sts_type           sts,
   input  wire logic [DATA_WIDTH-1:0] dividend,
   input  wire logic [DATA_WIDTH-1:0] divisor,
   output      logic [DATA_WIDTH-1:0] quotient,
   output      logic                  special_case
);

   localparam int CntWidth = $clog2(DATA_WIDTH);
   localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] MaxPos = ~MinNeg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;    // dividend bits out, quotient bits in
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  spec_ff, spec_in;

   logic                  a_neg, b_neg, special;
   logic [DATA_WIDTH-1:0] a_mag, b_mag;
   logic [DATA_WIDTH:0]   rem_sh, diff;
   logic                  ge;

   // Operand magnitudes and special cases at load time
   always_comb begin
      a_neg   = dividend[DATA_WIDTH-1];
      b_neg   = divisor[DATA_WIDTH-1];
      a_mag   = a_neg ? (~dividend + DATA_WIDTH'(1)) : dividend;
      b_mag   = b_neg ? (~divisor + DATA_WIDTH'(1)) : divisor;
      special = (divisor == '0) || ((dividend == MinNeg) && (divisor == '1));
   end

   // One restoring step: shift in the next dividend bit, trial subtract
   always_comb begin
      rem_sh = {rem_ff, num_ff[DATA_WIDTH-1]};
      diff   = rem_sh - {1'b0, den_ff};
      ge     = !diff[DATA_WIDTH];
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      spec_in  = spec_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               den_in  = b_mag;
               rem_in  = '0;
               cnt_in  = CntWidth'(DATA_WIDTH - 1);
               neg_in  = a_neg ^ b_neg;
               spec_in = special;
               if (special) begin
                  num_in   = MaxPos;
                  state_in = ST_DONE;
               end else begin
                  num_in   = a_mag;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            num_in = {num_ff[DATA_WIDTH-2:0], ge};
            cnt_in = cnt_ff - CntWidth'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // apply the sign when exactly one operand was negative
            num_in   = neg_ff ? (~num_ff + DATA_WIDTH'(1)) : num_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state; payload registers run without reset
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      spec_ff <= spec_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign sts.ready    = (state_ff == ST_IDLE);
   assign sts.done     = (state_ff == ST_DONE);
   assign quotient     = num_ff;
   assign special_case = spec_ff;

endmodule

`default_nettype wire

// File: hdl/signed_integer_divider.sv
// Top level of the signed integer divider: handshakes, divide core, output register.
// Depends on sid_pkg, sid_req_if, sid_rsp_if and sid_core.
//
//   channel  | direction | transfer carries
//   ---------+-----------+------------------------------------
//   req_ch   | in        | dividend, divisor (signed)
//   rsp_ch   | out       | quotient (signed), special_case
//
// After its transfer an operand pair is loaded, divided by the shared trial
// subtractor (one quotient bit each step), given its sign in a fix-up step and
// moved to the output register once that is free; then the core is free again.
// Special cases skip the division.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled result waits in the output register while the next pair divides.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_divider
   import sid_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   sid_req_if.sink  req_ch,
   sid_rsp_if.source rsp_ch
);

   sid_ctl_type           ctl;
   sid_sts_type           sts;
   logic [DATA_WIDTH-1:0] core_quotient;
   logic                  core_special;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff, rsp_quotient_in;
   logic                  rsp_special_ff, rsp_special_in;

   // Start on a request transfer; hand over once the output register is free
   assign req_ch.ready = sts.ready;
   assign ctl.start    = req_ch.valid && sts.ready;
   assign ctl.take     = sts.done && (!rsp_valid_ff || rsp_ch.ready);

   sid_core #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sts          (sts),
      .dividend     ($unsigned(req_ch.dividend)),
      .divisor      ($unsigned(req_ch.divisor)),
      .quotient     (core_quotient),
      .special_case (core_special)
   );

   // Output register: load on hand-over, drop valid after a response transfer
   always_comb begin
      rsp_quotient_in = rsp_quotient_ff;
      rsp_special_in  = rsp_special_ff;
      if (ctl.take) begin
         rsp_valid_in    = 1'b1;
         rsp_quotient_in = core_quotient;
         rsp_special_in  = core_special;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_quotient_ff <= rsp_quotient_in;
      rsp_special_ff  <= rsp_special_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.quotient     = $signed(rsp_quotient_ff);
   assign rsp_ch.special_case = rsp_special_ff;

endmodule

`default_nettype wire
